FILE: hw/rtl/hdbw_pkg.sv
// ----------------------------------------------------------------------------
// hdbw_pkg: shared types and constants for the hex dump record parser
// Character token carried from the classifier to the parser, parser phases
// and result codes.
// ----------------------------------------------------------------------------
package hdbw_pkg;

  localparam int unsigned DigitW    = 9;   // digit value, two's complement
  localparam int unsigned LineBytes = 16;
  localparam int unsigned MaxBlanks = 3;

  localparam logic [7:0] ChEol  = 8'h0A;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChSl   = 8'h2F;
  localparam logic [7:0] ChCol  = 8'h3A;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLa   = 8'h61;
  localparam logic [7:0] ChLz   = 8'h7A;

  localparam logic [DigitW-1:0] OffZero  = 9'd48;  // '0'
  localparam logic [DigitW-1:0] OffUpper = 9'd55;  // 'A' - 10
  localparam logic [DigitW-1:0] OffLower = 9'd87;  // 'a' - 10

  typedef enum logic [1:0] {
    ERR_NO_SLASH = 2'd0,
    ERR_NO_COLON = 2'd1,
    ERR_OFS_DIFF = 2'd2
  } err_code_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ERROR = 1'b1
  } res_kind_e;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_DEC,
    PH_DEC_SP,
    PH_HEX_LEAD,
    PH_HEX,
    PH_HEX_SP,
    PH_BYTES_LEAD,
    PH_NIB2,
    PH_GAP,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic              eol;
    logic              blank;
    logic              slash;
    logic              colon;
    logic [DigitW-1:0] dec_dig;
    logic [DigitW-1:0] hex_dig;
  } tok_t;

endpackage

FILE: hw/rtl/hdbw_front.sv
// ----------------------------------------------------------------------------
// hdbw_front: character classifier
// Decodes each incoming character into delimiter flags and digit values and
// hands the token to the queue.
// ----------------------------------------------------------------------------
module hdbw_front (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] ch
  output logic          tok_valid_o,
  input  logic          tok_ready_i,
  output hdbw_pkg::tok_t tok_o
);
  import hdbw_pkg::*;

  logic [DigitW-1:0] ch_ext;

  assign ch_ext = {1'b0, s_axis_tdata};

  always_comb begin
    tok_o.eol     = (s_axis_tdata == ChEol) || (s_axis_tdata == ChNul);
    tok_o.blank   = (s_axis_tdata == ChSp);
    tok_o.slash   = (s_axis_tdata == ChSl);
    tok_o.colon   = (s_axis_tdata == ChCol);
    tok_o.dec_dig = ch_ext - OffZero;
    // unchecked digits: anything goes, negatives wrap in two's complement
    if (s_axis_tdata <= ChNine) begin
      tok_o.hex_dig = ch_ext - OffZero;
    end else if ((s_axis_tdata >= ChLa) && (s_axis_tdata <= ChLz)) begin
      tok_o.hex_dig = ch_ext - OffLower;
    end else begin
      tok_o.hex_dig = ch_ext - OffUpper;
    end
  end

  assign tok_valid_o   = s_axis_tvalid;
  assign s_axis_tready = tok_ready_i;

endmodule

FILE: hw/rtl/hdbw_queue.sv
// ----------------------------------------------------------------------------
// hdbw_queue: two-entry token queue
// Decouples the classifier from the parser so either side can stall.
// ----------------------------------------------------------------------------
module hdbw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hdbw_pkg::tok_t in_tok_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hdbw_pkg::tok_t out_tok_o
);
  import hdbw_pkg::*;

  tok_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_tok_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_tok_i;
    end
  end

endmodule

FILE: hw/rtl/hdbw_back.sv
// ----------------------------------------------------------------------------
// hdbw_back: record parser
// Runs the line state machine on classified tokens, accumulates and checks
// the offsets and registers at most one byte write or error word per token.
// ----------------------------------------------------------------------------
module hdbw_back #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_valid_i,
  output logic           tok_ready_o,
  input  hdbw_pkg::tok_t tok_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [47:0]    m_axis_tdata,  // [31:0] address, [39:32] data, [41:40] error_code
  output logic           m_axis_tuser   // [0] kind
);
  import hdbw_pkg::*;

  localparam int unsigned AW = ADDR_WIDTH;

  phase_e        phase_q, phase_d;
  logic          halted_q, halted_d;
  logic [AW-1:0] dec_q, dec_d;
  logic [AW-1:0] hex_q, hex_d;
  logic [4:0]    nbytes_q, nbytes_d;
  logic [2:0]    blanks_q, blanks_d;
  logic [7:0]    high_q, high_d;

  logic          ovalid_q, ovalid_d;
  logic          okind_q, okind_d;
  logic [31:0]   oaddr_q, oaddr_d;
  logic [7:0]    odata_q, odata_d;
  logic [1:0]    oerr_q, oerr_d;

  logic          fire, run;
  logic [AW-1:0] dec_dig_x, hex_dig_x, dec_acc, hex_acc, wr_addr;
  logic [63:0]   wr_addr_w;
  logic          ofs_eq;
  logic [4:0]    nbytes_inc;
  logic [2:0]    blanks_inc;
  logic          emit_wr, emit_err;
  err_code_e     err_code;

  // a token is taken only when the result slot is free or draining
  assign fire        = tok_valid_i && (!ovalid_q || m_axis_tready);
  assign run         = fire && !halted_q;
  assign tok_ready_o = fire;

  assign dec_dig_x  = {{(AW-DigitW){tok_i.dec_dig[DigitW-1]}}, tok_i.dec_dig};
  assign hex_dig_x  = {{(AW-DigitW){tok_i.hex_dig[DigitW-1]}}, tok_i.hex_dig};
  assign dec_acc    = (dec_q << 3) + (dec_q << 1) + dec_dig_x;
  assign hex_acc    = (hex_q << 4) + hex_dig_x;
  assign ofs_eq     = (dec_q == hex_q);
  assign wr_addr    = dec_q + AW'(nbytes_q);
  assign wr_addr_w  = 64'(wr_addr);
  assign nbytes_inc = nbytes_q + 5'd1;
  assign blanks_inc = blanks_q + 3'd1;

  // next phase and halt
  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    emit_err = 1'b0;
    emit_wr  = 1'b0;
    err_code = ERR_NO_SLASH;
    if (run) begin
      unique case (phase_q)
        PH_LEAD, PH_DEC: begin
          if (tok_i.eol) begin
            emit_err = 1'b1;
            err_code = ERR_NO_SLASH;
          end else if (tok_i.slash) begin
            phase_d = PH_HEX_LEAD;
          end else if (tok_i.blank) begin
            if (phase_q == PH_DEC) phase_d = PH_DEC_SP;
          end else begin
            phase_d = PH_DEC;
          end
        end
        PH_DEC_SP: begin
          if (tok_i.slash) begin
            phase_d = PH_HEX_LEAD;
          end else if (!tok_i.blank) begin
            emit_err = 1'b1;
            err_code = ERR_NO_SLASH;
          end
        end
        PH_HEX_LEAD, PH_HEX: begin
          if (tok_i.eol) begin
            emit_err = 1'b1;
            err_code = ERR_NO_COLON;
          end else if (tok_i.colon) begin
            if (ofs_eq) begin
              phase_d = PH_BYTES_LEAD;
            end else begin
              emit_err = 1'b1;
              err_code = ERR_OFS_DIFF;
            end
          end else if (tok_i.blank) begin
            if (phase_q == PH_HEX) phase_d = PH_HEX_SP;
          end else begin
            phase_d = PH_HEX;
          end
        end
        PH_HEX_SP: begin
          if (tok_i.colon) begin
            if (ofs_eq) begin
              phase_d = PH_BYTES_LEAD;
            end else begin
              emit_err = 1'b1;
              err_code = ERR_OFS_DIFF;
            end
          end else if (!tok_i.blank) begin
            emit_err = 1'b1;
            err_code = ERR_NO_COLON;
          end
        end
        PH_BYTES_LEAD, PH_GAP: begin
          if (tok_i.eol) begin
            phase_d = PH_LEAD;
          end else if (tok_i.blank) begin
            if ((phase_q == PH_GAP) && (blanks_inc > 3'(MaxBlanks))) phase_d = PH_SKIP;
          end else begin
            phase_d = PH_NIB2;
          end
        end
        PH_NIB2: begin
          if (tok_i.eol) begin
            phase_d = PH_LEAD;
          end else begin
            emit_wr = 1'b1;
            phase_d = (nbytes_inc >= 5'(LineBytes)) ? PH_SKIP : PH_GAP;
          end
        end
        PH_SKIP: begin
          if (tok_i.eol) phase_d = PH_LEAD;
        end
        default: begin
          phase_d = PH_LEAD;
        end
      endcase
      if (emit_err) halted_d = 1'b1;
    end
  end

  // line datapath
  always_comb begin
    dec_d    = dec_q;
    hex_d    = hex_q;
    nbytes_d = nbytes_q;
    blanks_d = blanks_q;
    high_d   = high_q;
    if (run) begin
      case (phase_q)
        PH_LEAD, PH_DEC: begin
          if (!tok_i.eol && !tok_i.slash && !tok_i.blank) dec_d = dec_acc;
        end
        PH_HEX_LEAD, PH_HEX: begin
          if (!tok_i.eol && !tok_i.colon && !tok_i.blank) hex_d = hex_acc;
        end
        PH_BYTES_LEAD, PH_GAP: begin
          if (!tok_i.eol) begin
            if (tok_i.blank) begin
              if (phase_q == PH_GAP) blanks_d = blanks_inc;
            end else begin
              high_d = tok_i.hex_dig[7:0];
            end
          end
        end
        PH_NIB2: begin
          if (!tok_i.eol) begin
            nbytes_d = nbytes_inc;
            blanks_d = 3'd0;
          end
        end
        default: begin
        end
      endcase
      // start of a new line clears the line state
      if (tok_i.eol && ((phase_q == PH_BYTES_LEAD) || (phase_q == PH_GAP) ||
                        (phase_q == PH_NIB2) || (phase_q == PH_SKIP))) begin
        dec_d    = '0;
        hex_d    = '0;
        nbytes_d = 5'd0;
        blanks_d = 3'd0;
        high_d   = 8'd0;
      end
    end
  end

  // result word
  always_comb begin
    ovalid_d = ovalid_q;
    okind_d  = okind_q;
    oaddr_d  = oaddr_q;
    odata_d  = odata_q;
    oerr_d   = oerr_q;
    if (fire) begin
      ovalid_d = emit_wr || emit_err;
      okind_d  = emit_err ? KIND_ERROR : KIND_WRITE;
      oaddr_d  = emit_wr ? wr_addr_w[31:0] : 32'd0;
      odata_d  = emit_wr ? ({high_q[3:0], 4'd0} | tok_i.hex_dig[7:0]) : 8'd0;
      oerr_d   = emit_err ? err_code : 2'd0;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      halted_q <= 1'b0;
      dec_q    <= '0;
      hex_q    <= '0;
      nbytes_q <= 5'd0;
      blanks_q <= 3'd0;
      high_q   <= 8'd0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
      dec_q    <= dec_d;
      hex_q    <= hex_d;
      nbytes_q <= nbytes_d;
      blanks_q <= blanks_d;
      high_q   <= high_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oaddr_q <= oaddr_d;
    odata_q <= odata_d;
    oerr_q  <= oerr_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = {6'd0, oerr_q, odata_q, oaddr_q};

endmodule

FILE: hw/rtl/hex_dump_record_to_byte_writes_unit.sv
// ----------------------------------------------------------------------------
// hex_dump_record_to_byte_writes_unit: hex dump text to byte writes
// Each character is classified, held in the token queue and its result word registered in the parser.
// Throughput: one character per cycle, set by the single-step line parser, while the result output is not stalled.
// The two-entry token queue lets input and output stall independently.
// Reset: asynchronous, active low; parser returns to start of line, unhalted.
// ----------------------------------------------------------------------------
module hex_dump_record_to_byte_writes_unit #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] address, [39:32] data, [41:40] error_code
  output logic        m_axis_tuser    // [0] kind
);
  import hdbw_pkg::*;

  tok_t fr_tok, bk_tok;
  logic fr_valid, fr_ready;
  logic bk_valid, bk_ready;

  hdbw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .tok_valid_o   (fr_valid),
    .tok_ready_i   (fr_ready),
    .tok_o         (fr_tok)
  );

  hdbw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_tok_i    (fr_tok),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_tok_o   (bk_tok)
  );

  hdbw_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (bk_valid),
    .tok_ready_o   (bk_ready),
    .tok_i         (bk_tok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
